// ===== rtl/core/bvfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage failsafe monitor package
// Shared widths, register indexes, reset values, the limit result struct and
// the post-multiply arithmetic helpers.
// ----------------------------------------------------------------------------
package bvfm_pkg;

    localparam int DATA_W = 16;
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int IDX_W  = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SOURCE_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_VOLTAGE_SCALE   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CURRENT_SCALE   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SMOOTHING       = 3'd3;
    localparam logic [IDX_W-1:0] CFG_VOLTAGE_CEILING = 3'd4;
    localparam logic [IDX_W-1:0] CFG_VOLTAGE_FLOOR   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_LAND_LIMIT      = 3'd6;
    localparam logic [IDX_W-1:0] CFG_DISARM_LIMIT    = 3'd7;

    // reset values
    localparam logic [DATA_W-1:0] RST_VOLTAGE_SCALE   = 16'd256;
    localparam logic [DATA_W-1:0] RST_CURRENT_SCALE   = 16'd256;
    localparam logic [DATA_W-1:0] RST_SMOOTHING       = 16'd0;
    localparam logic [DATA_W-1:0] RST_VOLTAGE_CEILING = 16'd65535;
    localparam logic [DATA_W-1:0] RST_VOLTAGE_FLOOR   = 16'd0;
    localparam logic [DATA_W-1:0] RST_LAND_LIMIT      = 16'd6500;
    localparam logic [DATA_W-1:0] RST_DISARM_LIMIT    = 16'd3000;

    // failsafe actions
    localparam logic ACT_LAND   = 1'b0;
    localparam logic ACT_DISARM = 1'b1;

    typedef struct packed {
        logic healthy;
        logic fire;
        logic action;
    } t_lim_res;

    // Q8.8 scale: drop eight fraction bits, saturate at full scale
    function automatic logic [DATA_W-1:0] sat_scale(input logic signed [PROD_W-1:0] p);
        logic [DATA_W-1:0] res;
        if (|p[PROD_W-1:2*DATA_W-8]) begin
            res = '1;
        end else begin
            res = p[2*DATA_W-9:8];
        end
        return res;
    endfunction

    // average = x + alpha*(prev - x), in Q16 with round half up
    function automatic logic [DATA_W-1:0] ema_out(input logic [DATA_W-1:0] x,
                                                 input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] acc;
        acc = $signed({2'b00, x, {DATA_W{1'b0}}}) + p
            + $signed(PROD_W'(1 << (DATA_W - 1)));
        return acc[2*DATA_W-1:DATA_W];
    endfunction

endpackage

// ===== rtl/core/bvfm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 17x17 multiply with a registered product; the product holds while
// the unit is not enabled.
// ----------------------------------------------------------------------------
module bvfm_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [bvfm_pkg::MUL_W-1:0]     i_a,
    input  logic signed [bvfm_pkg::MUL_W-1:0]     i_b,
    output logic signed [bvfm_pkg::PROD_W-1:0]    o_p
);

    logic signed [bvfm_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_p = r_prod;

endmodule

// ===== rtl/core/bvfm_limit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Undervoltage limit checker
// Holds the two limit latches and the healthy flag; checks the raw voltage
// against the land limit, then the disarm limit.
// ----------------------------------------------------------------------------
module bvfm_limit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_upd,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_raw_v,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_land_limit,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_disarm_limit,
    output bvfm_pkg::t_lim_res                o_res
);

    logic [1:0] r_latch;
    logic [1:0] n_latch;
    logic       r_ok;
    logic       n_ok;
    logic       cross_land;
    logic       cross_disarm;

    assign cross_land   = i_raw_v < i_land_limit;
    assign cross_disarm = i_raw_v < i_disarm_limit;

    always_comb begin
        n_latch      = r_latch;
        n_ok         = r_ok;
        o_res.fire   = 1'b0;
        o_res.action = bvfm_pkg::ACT_LAND;
        if (cross_land && !r_latch[0]) begin
            n_latch[0]   = 1'b1;
            n_ok         = 1'b0;
            o_res.fire   = 1'b1;
        end else if (cross_disarm && !r_latch[1]) begin
            n_latch[1]   = 1'b1;
            n_ok         = 1'b0;
            o_res.fire   = 1'b1;
            o_res.action = bvfm_pkg::ACT_DISARM;
        end else if (!cross_land && !cross_disarm) begin
            // all clear: drop both latches
            n_latch = 2'b00;
            n_ok    = 1'b1;
        end
        o_res.healthy = n_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 2'b00;
            r_ok    <= 1'b1;
        end else if (i_upd) begin
            r_latch <= n_latch;
            r_ok    <= n_ok;
        end
    end

    // healthy exactly when no limit is latched
    a_ok_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ok == !(r_latch[0] || r_latch[1]))
        else $error("healthy flag disagrees with latches");

    a_fire_unhealthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && o_res.fire) |=> !r_ok)
        else $error("fired limit left block healthy");

endmodule

// ===== rtl/core/battery_voltage_failsafe_monitor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage failsafe monitor
// Selects and scales the battery voltage, scales the current sense channel,
// smooths both with an exponential average, clamps the voltage and runs the
// two-step undervoltage failsafe.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                 payload
//  -------   ---   -----------------------   -------------------------------
//  in        in    i_in_valid / o_in_stall   battery_mv, chan0_mv, chan1_mv
//  out       out   o_out_valid / i_out_stall smooth_voltage_mv,
//                                            smooth_current_ma, healthy,
//                                            fire, action
//  cfg       in    i_cfg_we                  i_cfg_index, i_cfg_data
//
//  A sample passes through four issues of the shared 17x17 multiplier
//  (channel 0 scale, channel 1 scale, voltage average, current average),
//  the finish step that takes the last product, and the return to idle;
//  the input is stalled until then, so one sample is taken at a time.
//  Reset (synchronous, active low) clears averages, latches and result valid, and loads the configuration reset values.
//  A stalled result holds the finish step; the input is stalled meanwhile.
//
module battery_voltage_failsafe_monitor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_battery_mv,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_chan0_mv,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_chan1_mv,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bvfm_pkg::DATA_W-1:0]       o_smooth_voltage_mv,
    output logic [bvfm_pkg::DATA_W-1:0]       o_smooth_current_ma,
    output logic                              o_healthy,
    output logic                              o_fire,
    output logic                              o_action,
    input  logic                              i_cfg_we,
    input  logic [bvfm_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [bvfm_pkg::DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCV,  // issue channel 0 scale
        S_SCI,  // issue channel 1 scale, take raw voltage
        S_EMV,  // issue voltage average, take raw current
        S_EMI,  // issue current average, take new voltage average
        S_FIN   // take new current average, deliver result
    } t_state;

    t_state r_state;

    // configuration
    logic                          r_source_mode;
    logic [bvfm_pkg::DATA_W-1:0]   r_voltage_scale;
    logic [bvfm_pkg::DATA_W-1:0]   r_current_scale;
    logic [bvfm_pkg::DATA_W-1:0]   r_smoothing;
    logic [bvfm_pkg::DATA_W-1:0]   r_voltage_ceiling;
    logic [bvfm_pkg::DATA_W-1:0]   r_voltage_floor;
    logic [bvfm_pkg::DATA_W-1:0]   r_land_limit;
    logic [bvfm_pkg::DATA_W-1:0]   r_disarm_limit;

    // filter state
    logic [bvfm_pkg::DATA_W-1:0]   r_volt_avg;
    logic [bvfm_pkg::DATA_W-1:0]   r_curr_avg;

    // sample and working payload
    logic [bvfm_pkg::DATA_W-1:0]   r_batt;
    logic [bvfm_pkg::DATA_W-1:0]   r_ch0;
    logic [bvfm_pkg::DATA_W-1:0]   r_ch1;
    logic [bvfm_pkg::DATA_W-1:0]   r_raw_v;
    logic [bvfm_pkg::DATA_W-1:0]   r_raw_i;

    // result register
    logic                          r_out_valid;
    logic [bvfm_pkg::DATA_W-1:0]   r_out_volt;
    logic [bvfm_pkg::DATA_W-1:0]   r_out_curr;
    logic                          r_out_healthy;
    logic                          r_out_fire;
    logic                          r_out_action;

    logic                               in_xfer;
    logic                               out_free;
    logic                               fin_go;
    logic                               mul_en;
    logic signed [bvfm_pkg::MUL_W-1:0]  mul_a;
    logic signed [bvfm_pkg::MUL_W-1:0]  mul_b;
    logic signed [bvfm_pkg::PROD_W-1:0] mul_p;
    logic [bvfm_pkg::DATA_W-1:0]        n_raw_v;
    logic [bvfm_pkg::DATA_W-1:0]        n_volt_avg;
    logic [bvfm_pkg::DATA_W-1:0]        n_curr_avg;
    logic [bvfm_pkg::DATA_W-1:0]        volt_ema;
    logic [bvfm_pkg::DATA_W-1:0]        volt_ceil;
    bvfm_pkg::t_lim_res                 lim_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // result slot is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fin_go     = (r_state == S_FIN) && out_free;

    // multiplier operand select per sequencer step
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_SCV: begin
                mul_a = $signed({1'b0, r_ch0});
                mul_b = $signed({1'b0, r_voltage_scale});
            end
            S_SCI: begin
                mul_a = $signed({1'b0, r_ch1});
                mul_b = $signed({1'b0, r_current_scale});
            end
            S_EMV: begin
                mul_a = $signed({1'b0, r_smoothing});
                mul_b = $signed({1'b0, r_volt_avg}) - $signed({1'b0, r_raw_v});
            end
            S_EMI: begin
                mul_a = $signed({1'b0, r_smoothing});
                mul_b = $signed({1'b0, r_curr_avg}) - $signed({1'b0, r_raw_i});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    bvfm_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // post-multiply paths
    assign n_raw_v    = r_source_mode ? bvfm_pkg::sat_scale(mul_p) : r_batt;
    assign volt_ema   = bvfm_pkg::ema_out(r_raw_v, mul_p);
    // ceiling first, then floor: the floor wins when they cross
    assign volt_ceil  = (volt_ema > r_voltage_ceiling) ? r_voltage_ceiling : volt_ema;
    assign n_volt_avg = (volt_ceil < r_voltage_floor) ? r_voltage_floor : volt_ceil;
    assign n_curr_avg = bvfm_pkg::ema_out(r_raw_i, mul_p);

    bvfm_limit u_limit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_upd          (fin_go),
        .i_raw_v        (r_raw_v),
        .i_land_limit   (r_land_limit),
        .i_disarm_limit (r_disarm_limit),
        .o_res          (lim_res)
    );

    // sequencer, configuration, filter state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_out_valid       <= 1'b0;
            r_source_mode     <= 1'b0;
            r_voltage_scale   <= bvfm_pkg::RST_VOLTAGE_SCALE;
            r_current_scale   <= bvfm_pkg::RST_CURRENT_SCALE;
            r_smoothing       <= bvfm_pkg::RST_SMOOTHING;
            r_voltage_ceiling <= bvfm_pkg::RST_VOLTAGE_CEILING;
            r_voltage_floor   <= bvfm_pkg::RST_VOLTAGE_FLOOR;
            r_land_limit      <= bvfm_pkg::RST_LAND_LIMIT;
            r_disarm_limit    <= bvfm_pkg::RST_DISARM_LIMIT;
            r_volt_avg        <= '0;
            r_curr_avg        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bvfm_pkg::CFG_SOURCE_MODE:     r_source_mode     <= i_cfg_data[0];
                    bvfm_pkg::CFG_VOLTAGE_SCALE:   r_voltage_scale   <= i_cfg_data;
                    bvfm_pkg::CFG_CURRENT_SCALE:   r_current_scale   <= i_cfg_data;
                    bvfm_pkg::CFG_SMOOTHING:       r_smoothing       <= i_cfg_data;
                    bvfm_pkg::CFG_VOLTAGE_CEILING: r_voltage_ceiling <= i_cfg_data;
                    bvfm_pkg::CFG_VOLTAGE_FLOOR:   r_voltage_floor   <= i_cfg_data;
                    bvfm_pkg::CFG_LAND_LIMIT:      r_land_limit      <= i_cfg_data;
                    bvfm_pkg::CFG_DISARM_LIMIT:    r_disarm_limit    <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the result once the far side takes it
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_SCV;
                    end
                end
                S_SCV: r_state <= S_SCI;
                S_SCI: r_state <= S_EMV;
                S_EMV: r_state <= S_EMI;
                S_EMI: begin
                    r_volt_avg <= n_volt_avg;
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    // hold here until the result slot frees up
                    if (out_free) begin
                        r_curr_avg  <= n_curr_avg;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_batt <= i_battery_mv;
            r_ch0  <= i_chan0_mv;
            r_ch1  <= i_chan1_mv;
        end
        if (r_state == S_SCI) begin
            r_raw_v <= n_raw_v;
        end
        if (r_state == S_EMV) begin
            r_raw_i <= bvfm_pkg::sat_scale(mul_p);
        end
        if (fin_go) begin
            r_out_volt    <= r_volt_avg;
            r_out_curr    <= n_curr_avg;
            r_out_healthy <= lim_res.healthy;
            r_out_fire    <= lim_res.fire;
            r_out_action  <= lim_res.action;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_smooth_voltage_mv = r_out_volt;
    assign o_smooth_current_ma = r_out_curr;
    assign o_healthy           = r_out_healthy;
    assign o_fire              = r_out_fire;
    assign o_action            = r_out_action;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCV))
        else $error("accepted sample did not start the sequence");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the finish step");

    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("finish step overran a held result");

endmodule
